/* src/ogcf_pkg.sv */
// shared types, constants and helpers for the occupancy grid cell fusion block
`timescale 1ns / 1ps

package ogcf_pkg;

    // default sizing of the block
    localparam int P_GRID_DIM      = 512;
    localparam int P_LOCAL_DIM     = 2048;
    localparam int P_GLOBAL_RES_MM = 100;

    // register map, word index into the apb window
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_RADIUS    = 3'd2;
    localparam logic [2:0] REG_OFFSET_X  = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd4;
    localparam logic [2:0] REG_LOCAL_RES = 3'd5;
    localparam logic [2:0] REG_LOCAL_W   = 3'd6;
    localparam logic [2:0] REG_LOCAL_H   = 3'd7;

    // result status codes
    localparam logic [2:0] STAT_WRITTEN      = 3'd0;
    localparam logic [2:0] STAT_FUSED        = 3'd1;
    localparam logic [2:0] STAT_UNKNOWN      = 3'd2;
    localparam logic [2:0] STAT_OUTSIDE_WIN  = 3'd3;
    localparam logic [2:0] STAT_OUTSIDE_GRID = 3'd4;

    // cell values
    localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
    localparam logic [6:0]        VAL_MAX      = 7'd100;
    localparam logic [6:0]        VAL_OCC      = 7'd100;
    localparam logic [6:0]        VAL_FREE     = 7'd0;
    localparam logic [7:0]        FUSE_THRESH  = 8'd80;

    // x / 5 for x up to 400, by reciprocal 205 / 1024
    localparam logic [9:0] DIV5_RECIP = 10'd205;

    typedef struct packed {
        logic signed [12:0] center_x;
        logic signed [12:0] center_y;
        logic        [10:0] window_radius;
        logic signed [20:0] offset_x_mm;
        logic signed [20:0] offset_y_mm;
        logic        [9:0]  local_res_mm;
        logic        [11:0] local_width;
        logic        [11:0] local_height;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WIN,
        S_POS,
        S_DIV,
        S_CORR,
        S_ADDR,
        S_READ,
        S_WRITE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic win;
        logic pos;
        logic div;
        logic corr;
        logic addr;
        logic read;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

    function automatic logic [6:0] div5(input logic [8:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'(DIV5_RECIP);
        return p[16:10];
    endfunction

endpackage

/* src/ogcf_regs.sv */
// apb configuration registers of the cell fusion block
`timescale 1ns / 1ps

module ogcf_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [4:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output ogcf_pkg::t_cfg o_cfg
);
    import ogcf_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign reg_idx = i_paddr[4:2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x      <= '0;
            r_cfg.center_y      <= '0;
            r_cfg.window_radius <= 11'd100;
            r_cfg.offset_x_mm   <= '0;
            r_cfg.offset_y_mm   <= '0;
            r_cfg.local_res_mm  <= 10'd100;
            r_cfg.local_width   <= 12'd2048;
            r_cfg.local_height  <= 12'd2048;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CENTER_X:  r_cfg.center_x      <= $signed(i_pwdata[12:0]);
                REG_CENTER_Y:  r_cfg.center_y      <= $signed(i_pwdata[12:0]);
                REG_RADIUS:    r_cfg.window_radius <= i_pwdata[10:0];
                REG_OFFSET_X:  r_cfg.offset_x_mm   <= $signed(i_pwdata[20:0]);
                REG_OFFSET_Y:  r_cfg.offset_y_mm   <= $signed(i_pwdata[20:0]);
                REG_LOCAL_RES: r_cfg.local_res_mm  <= i_pwdata[9:0];
                REG_LOCAL_W:   r_cfg.local_width   <= i_pwdata[11:0];
                REG_LOCAL_H:   r_cfg.local_height  <= i_pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X:  o_prdata = 32'(unsigned'(r_cfg.center_x));
            REG_CENTER_Y:  o_prdata = 32'(unsigned'(r_cfg.center_y));
            REG_RADIUS:    o_prdata = 32'(r_cfg.window_radius);
            REG_OFFSET_X:  o_prdata = 32'(unsigned'(r_cfg.offset_x_mm));
            REG_OFFSET_Y:  o_prdata = 32'(unsigned'(r_cfg.offset_y_mm));
            REG_LOCAL_RES: o_prdata = 32'(r_cfg.local_res_mm);
            REG_LOCAL_W:   o_prdata = 32'(r_cfg.local_width);
            REG_LOCAL_H:   o_prdata = 32'(r_cfg.local_height);
            default:       o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* src/ogcf_ctrl.sv */
// sequencer of the cell fusion block
`timescale 1ns / 1ps

module ogcf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ogcf_pkg::t_dp_stat i_stat,
    output ogcf_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import ogcf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WIN;
                end
            end
            S_WIN:   n_state = S_POS;
            S_POS:   n_state = S_DIV;
            S_DIV:   n_state = S_CORR;
            S_CORR:  n_state = S_ADDR;
            S_ADDR:  n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_WIN:   o_cmd.win    = 1'b1;
            S_POS:   o_cmd.pos    = 1'b1;
            S_DIV:   o_cmd.div    = 1'b1;
            S_CORR:  o_cmd.corr   = 1'b1;
            S_ADDR:  o_cmd.addr   = 1'b1;
            S_READ:  o_cmd.read   = 1'b1;
            S_WRITE: o_cmd.commit = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

/* src/ogcf_dp.sv */
// datapath: window check, local to global mapping, grid memory and fusion
`timescale 1ns / 1ps

module ogcf_dp #(
    parameter int GRID_DIM      = ogcf_pkg::P_GRID_DIM,
    parameter int LOCAL_DIM     = ogcf_pkg::P_LOCAL_DIM,
    parameter int GLOBAL_RES_MM = ogcf_pkg::P_GLOBAL_RES_MM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ogcf_pkg::t_cfg                i_cfg,
    input  ogcf_pkg::t_dp_cmd             i_cmd,
    output ogcf_pkg::t_dp_stat            o_stat,
    input  logic [$clog2(LOCAL_DIM)-1:0]  i_cell_col,
    input  logic [$clog2(LOCAL_DIM)-1:0]  i_cell_row,
    input  logic signed [7:0]             i_cell_value,
    output logic                          o_result_valid,
    output logic [2:0]                    o_status,
    output logic [$clog2(GRID_DIM)-1:0]   o_global_col,
    output logic [$clog2(GRID_DIM)-1:0]   o_global_row,
    output logic signed [7:0]             o_stored_value
);
    import ogcf_pkg::*;

    localparam int LW    = $clog2(LOCAL_DIM);
    localparam int GW    = $clog2(GRID_DIM);
    localparam int BW    = (LW > 12) ? LW : 12;
    localparam int XW    = BW + 2;
    localparam int PW    = LW + 11;
    localparam int NW    = ((PW > 22) ? PW : 22) + 2;
    localparam int D2    = 2 * GLOBAL_RES_MM;
    localparam int NLIM  = GRID_DIM * D2;
    localparam int NQW   = $clog2(NLIM);
    localparam int CW    = ((NW > NQW) ? NW : NQW) + 1;
    localparam int RECIP = (1 << NQW) / D2;
    localparam int MW    = 2 * NQW;
    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);

    // input capture
    logic [LW-1:0]      r_col;
    logic [LW-1:0]      r_row;
    logic signed [7:0]  r_val;

    // window stage
    logic               r_skip_win;
    logic               r_unknown;
    logic [6:0]         r_v;
    logic [PW-1:0]      r_px;
    logic [PW-1:0]      r_py;

    // position stage
    logic [NQW-1:0]     r_nqx;
    logic [NQW-1:0]     r_nqy;
    logic               r_outx;
    logic               r_outy;

    // quotient estimate, then corrected target
    logic [GW-1:0]      r_q0x;
    logic [GW-1:0]      r_q0y;
    logic [GW-1:0]      r_tx;
    logic [GW-1:0]      r_ty;
    logic [AW-1:0]      r_addr;

    // grid
    logic [7:0]         r_grid [DEPTH];
    logic [7:0]         r_mem_q;
    logic [AW-1:0]      r_clr_addr;

    // results
    logic               r_res_valid;
    logic [2:0]         r_out_status;
    logic [GW-1:0]      r_out_col;
    logic [GW-1:0]      r_out_row;
    logic signed [7:0]  r_out_val;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] rad;
    logic                 win_out;
    logic                 map_out;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic [MW-1:0]        prodx;
    logic [MW-1:0]        prody;
    logic [NQW-1:0]       remx;
    logic [NQW-1:0]       remy;
    logic [7:0]           fuse_sum;
    logic [6:0]           fused;
    logic [2:0]           status;
    logic signed [7:0]    stored;
    logic                 wr_en;

    // window and local map bounds
    always_comb begin
        dx      = $signed(XW'(r_col)) - XW'(i_cfg.center_x);
        dy      = $signed(XW'(r_row)) - XW'(i_cfg.center_y);
        rad     = $signed(XW'(i_cfg.window_radius));
        win_out = (dx > rad) || (dx < -rad) || (dy > rad) || (dy < -rad);
        map_out = (BW'(r_col) >= BW'(i_cfg.local_width)) ||
                  (BW'(r_row) >= BW'(i_cfg.local_height));
    end

    // numerator in half millimetres: (2i+1)*res + 2*offset
    always_comb begin
        nx = $signed(NW'(r_px)) + (NW'(i_cfg.offset_x_mm) <<< 1);
        ny = $signed(NW'(r_py)) + (NW'(i_cfg.offset_y_mm) <<< 1);
    end

    // floor reciprocal undershoots the quotient by at most one
    always_comb begin
        prodx = MW'(r_nqx) * MW'(RECIP);
        prody = MW'(r_nqy) * MW'(RECIP);
        remx  = r_nqx - NQW'(r_q0x * D2);
        remy  = r_nqy - NQW'(r_q0y * D2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_cell_col;
            r_row <= i_cell_row;
            r_val <= i_cell_value;
        end
        if (i_cmd.win) begin
            r_skip_win <= win_out || map_out;
            r_unknown  <= r_val < 0;
            r_v        <= (r_val > $signed({1'b0, VAL_MAX})) ? VAL_MAX : r_val[6:0];
            r_px       <= PW'({r_col, 1'b1}) * PW'(i_cfg.local_res_mm);
            r_py       <= PW'({r_row, 1'b1}) * PW'(i_cfg.local_res_mm);
        end
        if (i_cmd.pos) begin
            r_nqx  <= nx[NQW-1:0];
            r_nqy  <= ny[NQW-1:0];
            r_outx <= nx[NW-1] || (CW'(nx) >= $signed(CW'(NLIM)));
            r_outy <= ny[NW-1] || (CW'(ny) >= $signed(CW'(NLIM)));
        end
        if (i_cmd.div) begin
            r_q0x <= prodx[NQW+GW-1:NQW];
            r_q0y <= prody[NQW+GW-1:NQW];
        end
        if (i_cmd.corr) begin
            r_tx <= (remx >= NQW'(D2)) ? r_q0x + GW'(1) : r_q0x;
            r_ty <= (remy >= NQW'(D2)) ? r_q0y + GW'(1) : r_q0y;
        end
        if (i_cmd.addr) begin
            r_addr <= AW'(r_ty) * AW'(GRID_DIM) + AW'(r_tx);
        end
    end

    // grid memory: one write port shared by the clear sweep and the commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_grid[r_clr_addr] <= CELL_UNKNOWN;
        end else if (wr_en) begin
            r_grid[r_addr] <= stored;
        end
        if (i_cmd.read) begin
            r_mem_q <= r_grid[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_stat.clear_last = (r_clr_addr == AW'(DEPTH - 1));

    // fusion and status
    always_comb begin
        fuse_sum = {1'b0, div5({2'b00, r_mem_q[6:0]})} + {1'b0, div5({r_v, 2'b00})};
        fused    = (fuse_sum >= FUSE_THRESH) ? VAL_OCC : VAL_FREE;
        stored   = CELL_UNKNOWN;
        wr_en    = 1'b0;
        if (r_skip_win) begin
            status = STAT_OUTSIDE_WIN;
        end else if (r_unknown) begin
            status = STAT_UNKNOWN;
        end else if (r_outx || r_outy) begin
            status = STAT_OUTSIDE_GRID;
        end else if (r_mem_q[7]) begin
            status = STAT_WRITTEN;
            stored = $signed({1'b0, r_v});
            wr_en  = i_cmd.commit;
        end else begin
            status = STAT_FUSED;
            stored = $signed({1'b0, fused});
            wr_en  = i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= status;
            r_out_val    <= stored;
            r_out_col    <= wr_en ? r_tx : '0;
            r_out_row    <= wr_en ? r_ty : '0;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_status       = r_out_status;
    assign o_global_col   = r_out_col;
    assign o_global_row   = r_out_row;
    assign o_stored_value = r_out_val;

endmodule

/* src/occupancy_grid_cell_fusion_core.sv */
// top level of the occupancy grid cell fusion block
`timescale 1ns / 1ps

// channel    | direction | handshake                        | payload
// -----------+-----------+----------------------------------+-------------------------------
// cell in    | in        | start high, busy low             | i_cell_col, i_cell_row,
//            |           |                                  | i_cell_value
// result out | out       | o_result_valid, one cycle        | o_status, o_global_col,
//            |           |                                  | o_global_row, o_stored_value
// config     | in / out  | apb write when psel, penable,    | paddr, pwdata, prdata
//            |           | pwrite high (pready tied high)   |
//
// after an accepted request busy stays high while the sequencer walks window check,
// position multiply, reciprocal multiply, quotient correction, address, grid read and
// write-back; the result strobe is registered from write-back and rises as busy falls;
// the next request can be taken at the edge that ends the strobe, one request at a time
// after reset the grid is swept to unknown, one cell a cycle, over all GRID_DIM*GRID_DIM
// cells (262144 at the default size); busy is high during the sweep
// config writes are taken at any time and should only land while busy is low
// the result is shown for exactly one cycle and the receiver cannot stall it

module occupancy_grid_cell_fusion_core #(
    parameter int GRID_DIM      = ogcf_pkg::P_GRID_DIM,
    parameter int LOCAL_DIM     = ogcf_pkg::P_LOCAL_DIM,
    parameter int GLOBAL_RES_MM = ogcf_pkg::P_GLOBAL_RES_MM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cell request
    input  logic                          start,
    output logic                          busy,
    input  logic [$clog2(LOCAL_DIM)-1:0]  i_cell_col,
    input  logic [$clog2(LOCAL_DIM)-1:0]  i_cell_row,
    input  logic signed [7:0]             i_cell_value,
    // result
    output logic                          o_result_valid,
    output logic [2:0]                    o_status,
    output logic [$clog2(GRID_DIM)-1:0]   o_global_col,
    output logic [$clog2(GRID_DIM)-1:0]   o_global_row,
    output logic signed [7:0]             o_stored_value,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ogcf_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // no wait states on the config port
    assign pready = 1'b1;

    // register file, read back combinationally in the access phase
    ogcf_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // sequencer: clear sweep after reset, then one request at a time
    ogcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // arithmetic, grid memory and result registers
    ogcf_dp #(
        .GRID_DIM      (GRID_DIM),
        .LOCAL_DIM     (LOCAL_DIM),
        .GLOBAL_RES_MM (GLOBAL_RES_MM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cell_value   (i_cell_value),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_global_col   (o_global_col),
        .o_global_row   (o_global_row),
        .o_stored_value (o_stored_value)
    );

endmodule

/* src/ogcf_checker.sv */
// port level checks of the cell fusion block, bound to the top level
`timescale 1ns / 1ps

module ogcf_checker #(
    parameter int GRID_DIM = ogcf_pkg::P_GRID_DIM
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_result_valid,
    input logic [2:0]                  o_status,
    input logic [$clog2(GRID_DIM)-1:0] o_global_col,
    input logic [$clog2(GRID_DIM)-1:0] o_global_row,
    input logic signed [7:0]           o_stored_value
);
    import ogcf_pkg::*;

    // an accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // one strobe per request, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // a result closes a request that held busy
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a request in flight");

    // skipped cells report no target and unknown value
    a_skip_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == STAT_UNKNOWN || o_status == STAT_OUTSIDE_WIN ||
                            o_status == STAT_OUTSIDE_GRID))
        |-> (o_global_col == '0 && o_global_row == '0 && o_stored_value == CELL_UNKNOWN))
        else $error("skipped cell carries a payload");

    // fused cells end up thresholded
    a_fused_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STAT_FUSED)
        |-> (o_stored_value == 8'sd0 || o_stored_value == 8'sd100))
        else $error("fused value not thresholded");

endmodule

bind occupancy_grid_cell_fusion_core ogcf_checker #(
    .GRID_DIM (GRID_DIM)
) u_ogcf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_global_col   (o_global_col),
    .o_global_row   (o_global_row),
    .o_stored_value (o_stored_value)
);

/* tb/sv/testbench.sv */
// self-checking testbench for the occupancy grid cell fusion core
`timescale 1ns / 1ps

module testbench;
    import ogcf_pkg::*;

    localparam int  CLK_HALF     = 4;
    // grid sweep after reset plus ~2000 requests at worst gap and latency, many times over
    localparam longint RUN_LIMIT = 1_500_000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  GRID_CELLS   = P_GRID_DIM * P_GRID_DIM;
    localparam int  MAX_GAP      = 11;

    // one local cell request
    typedef struct packed {
        logic [10:0]       col;
        logic [10:0]       row;
        logic signed [7:0] value;
    } t_cell_req;

    // one fusion result
    typedef struct packed {
        logic [2:0]        status;
        logic [8:0]        gcol;
        logic [8:0]        grow;
        logic signed [7:0] stored;
    } t_cell_res;

    // directed row: request plus a hand-typed result where it is obvious
    typedef struct packed {
        t_cell_req req;
        logic      typed;
        t_cell_res res;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [10:0]       cell_col     = '0;
    logic [10:0]       cell_row     = '0;
    logic signed [7:0] cell_value   = '0;
    logic              result_valid;
    logic [2:0]        status;
    logic [8:0]        global_col;
    logic [8:0]        global_row;
    logic signed [7:0] stored_value;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [4:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state: register shadow and global grid copy
    t_cfg              grid_cfg = '{0, 0, 100, 0, 0, 100, 2048, 2048};
    logic signed [7:0] fuse_grid [GRID_CELLS];
    t_cell_res         fuse_expect_q [$];
    t_cell_res         want;
    bit                run_failed  = 1'b0;
    longint            cycle_count = 0;

    // directed requests, run on the reset configuration with the grid all unknown
    t_dir_row dir_tab [24] = '{
        // first write, then fuse up and down
        '{'{0, 0, 50},       1, '{STAT_WRITTEN, 0, 0, 50}},
        '{'{0, 0, 100},      1, '{STAT_FUSED, 0, 0, 100}},
        '{'{0, 0, 0},        1, '{STAT_FUSED, 0, 0, 0}},
        // unknown input inside the window
        '{'{0, 0, -1},       1, '{STAT_UNKNOWN, 0, 0, -1}},
        // window check wins over the unknown check
        '{'{101, 0, -1},     1, '{STAT_OUTSIDE_WIN, 0, 0, -1}},
        '{'{0, 101, 5},      1, '{STAT_OUTSIDE_WIN, 0, 0, -1}},
        '{'{2047, 2047, 0},  1, '{STAT_OUTSIDE_WIN, 0, 0, -1}},
        '{'{3, 2047, 10},    1, '{STAT_OUTSIDE_WIN, 0, 0, -1}},
        '{'{2047, 3, 10},    1, '{STAT_OUTSIDE_WIN, 0, 0, -1}},
        // window corner, value saturated to 100
        '{'{100, 100, 127},  1, '{STAT_WRITTEN, 100, 100, 100}},
        // most negative value is treated as unknown
        '{'{100, 100, -128}, 1, '{STAT_UNKNOWN, 0, 0, -1}},
        '{'{1, 1, -2},       1, '{STAT_UNKNOWN, 0, 0, -1}},
        '{'{5, 7, 101},      1, '{STAT_WRITTEN, 5, 7, 100}},
        '{'{5, 7, 99},       1, '{STAT_FUSED, 5, 7, 100}},
        // fused sum exactly at the threshold
        '{'{7, 5, 1},        1, '{STAT_WRITTEN, 7, 5, 1}},
        '{'{7, 5, 100},      1, '{STAT_FUSED, 7, 5, 100}},
        // fused sum one below the threshold
        '{'{9, 9, 0},        1, '{STAT_WRITTEN, 9, 9, 0}},
        '{'{9, 9, 99},       1, '{STAT_FUSED, 9, 9, 0}},
        '{'{100, 0, 20},     1, '{STAT_WRITTEN, 100, 0, 20}},
        '{'{0, 100, 20},     1, '{STAT_WRITTEN, 0, 100, 20}},
        '{'{100, 0, 100},    1, '{STAT_FUSED, 100, 0, 100}},
        '{'{50, 60, 77},     0, '0},
        '{'{50, 60, 64},     0, '0},
        '{'{100, 100, 0},    0, '0}
    };

    // extreme register settings, each run for a short stretch
    t_cfg corner_cfg [9] = '{
        // every cell in window, most negative offsets, 1000 mm cells
        '{2047, 2047, 2047, -1048576, -1048576, 1000, 2048, 2048},
        // largest offsets, narrowest cells: beyond the grid
        '{0, 0, 2047, 1048575, 1048575, 1, 2048, 2048},
        // zero resolution: every cell lands on one global cell
        '{1024, 1024, 2047, 25550, 0, 0, 2048, 2048},
        // zero resolution with a negative position
        '{1024, 1024, 2047, 0, -1, 0, 2048, 2048},
        // zero local width, then zero local height
        '{0, 0, 100, 0, 0, 100, 0, 2048},
        '{0, 0, 100, 0, 0, 100, 2048, 0},
        // one-cell local map, zero radius
        '{0, 0, 0, 0, 0, 1000, 1, 1},
        // window centers at -2048 and at 4095, the top of their range
        '{-2048, -2048, 2047, 0, 0, 100, 2048, 2048},
        '{4095, 4095, 2047, 0, 0, 100, 2048, 2048}
    };

    occupancy_grid_cell_fusion_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cell_col     (cell_col),
        .i_cell_row     (cell_row),
        .i_cell_value   (cell_value),
        .o_result_valid (result_valid),
        .o_status       (status),
        .o_global_col   (global_col),
        .o_global_row   (global_row),
        .o_stored_value (stored_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // expected fusion result for one request; updates the grid copy
    function automatic t_cell_res fuse_predict(input t_cell_req c);
        longint    i, j, v, dx, dy, rad, nx, ny, tx, ty, m, f;
        int        idx;
        t_cell_res r;
        i   = longint'(c.col);
        j   = longint'(c.row);
        v   = longint'($signed(c.value));
        dx  = i - longint'($signed(grid_cfg.center_x));
        dy  = j - longint'($signed(grid_cfg.center_y));
        rad = longint'(grid_cfg.window_radius);
        r.status = STAT_OUTSIDE_WIN;
        r.gcol   = '0;
        r.grow   = '0;
        r.stored = CELL_UNKNOWN;
        // window and local map first, then unknown, then global bounds
        if (i >= longint'(grid_cfg.local_width) || j >= longint'(grid_cfg.local_height) ||
            dx > rad || dx < -rad || dy > rad || dy < -rad) begin
            r.status = STAT_OUTSIDE_WIN;
        end else if (v < 0) begin
            r.status = STAT_UNKNOWN;
        end else begin
            if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
            // cell center in mm, doubled to stay in integers
            nx = (2 * i + 1) * longint'(grid_cfg.local_res_mm)
                 + 2 * longint'($signed(grid_cfg.offset_x_mm));
            ny = (2 * j + 1) * longint'(grid_cfg.local_res_mm)
                 + 2 * longint'($signed(grid_cfg.offset_y_mm));
            tx = nx / (2 * P_GLOBAL_RES_MM);
            ty = ny / (2 * P_GLOBAL_RES_MM);
            if (nx < 0 || ny < 0 || tx >= P_GRID_DIM || ty >= P_GRID_DIM) begin
                r.status = STAT_OUTSIDE_GRID;
            end else begin
                idx = int'(ty) * P_GRID_DIM + int'(tx);
                m   = longint'(fuse_grid[idx]);
                if (m < 0) begin
                    r.stored = 8'(v);
                    r.status = STAT_WRITTEN;
                end else begin
                    // 0.2 old plus 0.8 new, then hard threshold
                    f        = m / 5 + (4 * v) / 5;
                    r.stored = (f >= longint'(FUSE_THRESH)) ? 8'(VAL_OCC) : 8'(VAL_FREE);
                    r.status = STAT_FUSED;
                end
                fuse_grid[idx] = r.stored;
                r.gcol = 9'(tx);
                r.grow = 9'(ty);
            end
        end
        return r;
    endfunction

    // local coordinate near a window center, kept inside the local map range
    function automatic logic [10:0] pick_near(input logic signed [12:0] ctr,
                                              input logic [10:0] rad);
        longint p;
        p = longint'(ctr) + longint'($urandom_range(0, 2 * rad)) - longint'(rad);
        if (p < 0) p = 0;
        if (p > P_LOCAL_DIM - 1) p = P_LOCAL_DIM - 1;
        return 11'(p);
    endfunction

    // offset that puts the window center somewhere in the grid, now and then near its edge
    function automatic logic signed [20:0] focus_offset(input logic signed [12:0] ctr,
                                                         input logic [9:0] res);
        longint base, off;
        base = $urandom_range(0, 51199);
        if ($urandom_range(0, 7) == 0)
            base = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(50800, 51199);
        off = base - longint'(ctr) * longint'(res);
        if (off < -1048576) off = -1048576;
        if (off > 1048575) off = 1048575;
        return 21'(off);
    endfunction

    // small window mapped into the grid, so that global cells get hit again and again
    function automatic t_cfg focus_cfg();
        t_cfg c;
        c.window_radius = 11'($urandom_range(0, 6));
        c.center_x      = 13'($urandom_range(0, 1000));
        c.center_y      = 13'($urandom_range(0, 1000));
        c.local_res_mm  = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, 1000))
                                                      : 10'($urandom_range(1, 150));
        c.local_width   = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(1, 2048)) : 12'(2048);
        c.local_height  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(1, 2048)) : 12'(2048);
        c.offset_x_mm   = focus_offset(c.center_x, c.local_res_mm);
        c.offset_y_mm   = focus_offset(c.center_y, c.local_res_mm);
        return c;
    endfunction

    // mostly cells in the window with plausible values, the rest raw noise
    function automatic t_cell_req draw_cell(input t_cfg c);
        t_cell_req   pick;
        int unsigned k;
        if ($urandom_range(0, 9) == 0) begin
            pick.col   = 11'($urandom);
            pick.row   = 11'($urandom);
            pick.value = 8'($urandom);
        end else begin
            pick.col = pick_near(c.center_x, c.window_radius);
            pick.row = pick_near(c.center_y, c.window_radius);
            k = $urandom_range(0, 9);
            if (k < 7)
                pick.value = 8'($urandom_range(0, 100));
            else if (k == 7)
                pick.value = 8'($urandom_range(101, 127));
            else if (k == 8)
                pick.value = CELL_UNKNOWN;
            else
                pick.value = 8'($urandom_range(128, 254));
        end
        return pick;
    endfunction

    // apb write: setup, then access; the shadow follows at the accepting edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_CENTER_X:  grid_cfg.center_x      = data[12:0];
            REG_CENTER_Y:  grid_cfg.center_y      = data[12:0];
            REG_RADIUS:    grid_cfg.window_radius = data[10:0];
            REG_OFFSET_X:  grid_cfg.offset_x_mm   = data[20:0];
            REG_OFFSET_Y:  grid_cfg.offset_y_mm   = data[20:0];
            REG_LOCAL_RES: grid_cfg.local_res_mm  = data[9:0];
            REG_LOCAL_W:   grid_cfg.local_width   = data[11:0];
            REG_LOCAL_H:   grid_cfg.local_height  = data[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // signed registers go out sign-extended to the full bus
    task automatic apply_cfg(input t_cfg c);
        write_reg(REG_CENTER_X,  32'($signed(c.center_x)));
        write_reg(REG_CENTER_Y,  32'($signed(c.center_y)));
        write_reg(REG_RADIUS,    32'(c.window_radius));
        write_reg(REG_OFFSET_X,  32'($signed(c.offset_x_mm)));
        write_reg(REG_OFFSET_Y,  32'($signed(c.offset_y_mm)));
        write_reg(REG_LOCAL_RES, 32'(c.local_res_mm));
        write_reg(REG_LOCAL_W,   32'(c.local_width));
        write_reg(REG_LOCAL_H,   32'(c.local_height));
    endtask

    // drop start, then wait for every pending result and the tail of the pipeline
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (fuse_expect_q.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // present one request after a gap; start stays high when the gap is zero
    task automatic issue_cell(input t_cell_req c, input t_cell_res typed_res,
                              input logic use_typed, input int gap);
        t_cell_res pred;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        cell_col   <= c.col;
        cell_row   <= c.row;
        cell_value <= c.value;
        // accepted at the first edge that sees busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = fuse_predict(c);
        fuse_expect_q.insert(fuse_expect_q.size(), use_typed ? typed_res : pred);
    endtask

    // one register setting and a run of requests under it
    task automatic run_phase(input t_cfg c, input int n_items);
        int gmax;
        wait_idle();
        apply_cfg(c);
        // some phases run back to back with no gaps at all
        gmax = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        repeat (n_items) issue_cell(draw_cell(c), '0, 1'b0, $urandom_range(0, gmax));
    endtask

    // result checker: every strobe pairs with the oldest pending request
    always @(posedge i_clk) begin
        if (i_rst_n && result_valid === 1'b1) begin
            if (fuse_expect_q.size() == 0) begin
                $display("%0t: result with no request pending, status %0d col %0d row %0d",
                         $time, status, global_col, global_row);
                run_failed = 1'b1;
            end else begin
                want = fuse_expect_q.pop_front();
                if (status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                    run_failed = 1'b1;
                end
                if (global_col !== want.gcol) begin
                    $display("%0t: global_col expected %0d, got %0d",
                             $time, want.gcol, global_col);
                    run_failed = 1'b1;
                end
                if (global_row !== want.grow) begin
                    $display("%0t: global_row expected %0d, got %0d",
                             $time, want.grow, global_row);
                    run_failed = 1'b1;
                end
                if (stored_value !== want.stored) begin
                    $display("%0t: stored_value expected %0d, got %0d",
                             $time, want.stored, stored_value);
                    run_failed = 1'b1;
                end
            end
        end
    end

    // watchdog, sized for the grid sweep after reset plus the whole request stream
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, fuse_expect_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < GRID_CELLS; n++) fuse_grid[n] = CELL_UNKNOWN;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows on reset values; the first request waits out the grid sweep
        foreach (dir_tab[k])
            issue_cell(dir_tab[k].req, dir_tab[k].res, dir_tab[k].typed,
                       $urandom_range(0, MAX_GAP));

        // extreme settings, short runs
        foreach (corner_cfg[k]) run_phase(corner_cfg[k], 40);

        // random focused settings carry most of the traffic
        repeat (8) run_phase(focus_cfg(), 200);

        wait_idle();
        if (!run_failed && fuse_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
